[rtl/assert_macros.svh]
// assertion helpers, sampled on clk_i and quiet while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/ed_pkg.sv]
package ed_pkg;

  localparam int MAX_LEN = 64;
  localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int COST_W  = $clog2(MAX_LEN + 1);
  localparam int SYM_W   = 8;
  localparam int FUNC_W  = 2;
  localparam int DIST_W  = 7;
  localparam int DIST_MAX = 127;

  localparam logic [FUNC_W-1:0] FUNC_APPEND_FIRST  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_APPEND_SECOND = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMPUTE       = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [SYM_W-1:0]  symbol;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              truncated;
  } out_item_t;

  // memory port requests from the sequencer
  typedef struct packed {
    logic              a_re;
    logic [ADDR_W-1:0] a_raddr;
    logic              b_re;
    logic [ADDR_W-1:0] b_raddr;
    logic              c_re;
    logic [ADDR_W-1:0] c_raddr;
    logic              c_we;
    logic [ADDR_W-1:0] c_waddr;
    logic [COST_W-1:0] c_wdata;
  } mem_req_t;

  function automatic logic [DIST_W-1:0] sat_dist(input logic [COST_W-1:0] v);
    logic [31:0] wide;
    wide = 32'(v);
    if (wide > 32'(DIST_MAX)) begin
      return DIST_W'(DIST_MAX);
    end
    return DIST_W'(v);
  endfunction

endpackage

[rtl/ed_ram.sv]
module ed_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/ed_cell.sv]
module ed_cell (
  input  logic [ed_pkg::SYM_W-1:0]  a_sym_i,
  input  logic [ed_pkg::SYM_W-1:0]  b_sym_i,
  input  logic [ed_pkg::COST_W-1:0] diag_i,
  input  logic [ed_pkg::COST_W-1:0] above_i,
  input  logic [ed_pkg::COST_W-1:0] left_i,
  output logic [ed_pkg::COST_W-1:0] cost_o
);
  import ed_pkg::*;

  logic [COST_W-1:0] min_da;
  logic [COST_W-1:0] min_all;

  always_comb begin
    min_da  = (diag_i < above_i) ? diag_i : above_i;
    min_all = (min_da < left_i) ? min_da : left_i;
    if (a_sym_i == b_sym_i) begin
      cost_o = diag_i;
    end else begin
      cost_o = min_all + COST_W'(1);
    end
  end

endmodule

[rtl/ed_ctrl.sv]
module ed_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ed_pkg::COST_W-1:0] first_len_i,
  input  logic [ed_pkg::COST_W-1:0] second_len_i,
  input  logic [ed_pkg::SYM_W-1:0]  a_rdata_i,
  input  logic [ed_pkg::SYM_W-1:0]  b_rdata_i,
  input  logic [ed_pkg::COST_W-1:0] c_rdata_i,
  input  logic                      out_free_i,
  output ed_pkg::mem_req_t          req_o,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [ed_pkg::COST_W-1:0] dist_o
);
  import ed_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROW,
    ST_CELL,
    ST_FINISH
  } state_e;

  state_e            state_q;
  logic [COST_W-1:0] i_q, j_q, m_q, n_q;
  logic [COST_W-1:0] left_q, diag_q, dist_q;
  logic [COST_W-1:0] above;
  logic [COST_W-1:0] cost;

  // first row of the table is j itself, so it is never stored
  assign above = (i_q == COST_W'(1)) ? j_q : c_rdata_i;

  ed_cell u_cell (
    .a_sym_i (a_rdata_i),
    .b_sym_i (b_rdata_i),
    .diag_i  (diag_q),
    .above_i (above),
    .left_i  (left_q),
    .cost_o  (cost)
  );

  always_comb begin
    req_o         = '0;
    req_o.a_raddr = ADDR_W'(i_q - COST_W'(1));
    req_o.c_waddr = ADDR_W'(j_q - COST_W'(1));
    req_o.c_wdata = cost;
    case (state_q)
      ST_ROW: begin
        req_o.a_re = 1'b1;
        req_o.b_re = 1'b1;
        req_o.c_re = 1'b1;
      end
      ST_CELL: begin
        req_o.c_we = 1'b1;
        if (j_q != n_q) begin
          req_o.b_re    = 1'b1;
          req_o.b_raddr = ADDR_W'(j_q);
          req_o.c_re    = 1'b1;
          req_o.c_raddr = ADDR_W'(j_q);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      m_q     <= '0;
      n_q     <= '0;
      left_q  <= '0;
      diag_q  <= '0;
      dist_q  <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            m_q <= first_len_i;
            n_q <= second_len_i;
            i_q <= COST_W'(1);
            if (first_len_i == '0 || second_len_i == '0) begin
              dist_q  <= first_len_i | second_len_i;
              state_q <= ST_FINISH;
            end else begin
              state_q <= ST_ROW;
            end
          end
        end
        ST_ROW: begin
          j_q     <= COST_W'(1);
          left_q  <= i_q;
          diag_q  <= i_q - COST_W'(1);
          state_q <= ST_CELL;
        end
        ST_CELL: begin
          left_q <= cost;
          diag_q <= above;
          if (j_q == n_q) begin
            if (i_q == m_q) begin
              dist_q  <= cost;
              state_q <= ST_FINISH;
            end else begin
              i_q     <= i_q + COST_W'(1);
              state_q <= ST_ROW;
            end
          end else begin
            j_q <= j_q + COST_W'(1);
          end
        end
        ST_FINISH: begin
          if (out_free_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_FINISH) && out_free_i;
  assign dist_o = dist_q;

endmodule

[rtl/edit_distance_engine.sv]
// edit distance engine: Levenshtein distance between two byte strings
//
// input channel (in_valid_i / in_stall_o / in_item_i): func selects append to
// the first string, append to the second string, or compute. appends are
// taken while in_stall_o is low; a string holds up to MAX_LEN symbols and
// later symbols are dropped and remembered in the truncated flag. func 3 is
// swallowed silently. compute starts a row-by-row sweep of the cost table
// through one shared compare/min cell, clears both strings and the truncated
// flag, and yields one item on the output channel (out_valid_o /
// out_stall_i / out_item_o). for lengths m, n both nonzero the sweep visits
// one table cell per cycle, with an ST_ROW step at the start of each row to
// fetch the row symbol from the first string memory; with an empty string
// no sweep runs. in_stall_o stays high for the whole sweep. the result sits
// in an output register; while the receiver stalls, appends are still
// taken, and a following compute runs but holds its result until the
// register is free. reset clears lengths, flag and handshake state; string
// and cost memories start undefined and need no clear
`include "assert_macros.svh"

module edit_distance_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ed_pkg::in_item_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ed_pkg::out_item_t out_item_o
);
  import ed_pkg::*;

  logic              in_acc;
  logic              start;
  logic              app_first, app_second;
  logic              first_full, second_full;
  logic [COST_W-1:0] first_len_q, second_len_q;
  logic              overflow_q;
  logic              trunc_q;
  logic              out_valid_q;
  out_item_t         out_item_q;
  logic              out_free;

  mem_req_t          req;
  logic              ctrl_busy, ctrl_done;
  logic [COST_W-1:0] ctrl_dist;
  logic [SYM_W-1:0]  a_rdata, b_rdata;
  logic [COST_W-1:0] c_rdata;

  // no new item while the sweep owns the strings
  assign in_stall_o = ctrl_busy;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign start      = in_acc && (in_item_i.func == FUNC_COMPUTE);
  assign app_first  = in_acc && (in_item_i.func == FUNC_APPEND_FIRST);
  assign app_second = in_acc && (in_item_i.func == FUNC_APPEND_SECOND);

  assign first_full  = (first_len_q == COST_W'(MAX_LEN));
  assign second_full = (second_len_q == COST_W'(MAX_LEN));

  // result register is free when empty or being taken this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  // string lengths and overflow tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_len_q  <= '0;
      second_len_q <= '0;
      overflow_q   <= 1'b0;
      trunc_q      <= 1'b0;
    end else begin
      if (start) begin
        first_len_q  <= '0;
        second_len_q <= '0;
        overflow_q   <= 1'b0;
        trunc_q      <= overflow_q;
      end else if (app_first) begin
        if (first_full) begin
          overflow_q <= 1'b1;
        end else begin
          first_len_q <= first_len_q + COST_W'(1);
        end
      end else if (app_second) begin
        if (second_full) begin
          overflow_q <= 1'b1;
        end else begin
          second_len_q <= second_len_q + COST_W'(1);
        end
      end
    end
  end

  ed_ram #(
    .WIDTH (SYM_W),
    .DEPTH (MAX_LEN)
  ) u_first_ram (
    .clk_i   (clk_i),
    .we_i    (app_first && !first_full),
    .waddr_i (ADDR_W'(first_len_q)),
    .wdata_i (in_item_i.symbol),
    .re_i    (req.a_re),
    .raddr_i (req.a_raddr),
    .rdata_o (a_rdata)
  );

  ed_ram #(
    .WIDTH (SYM_W),
    .DEPTH (MAX_LEN)
  ) u_second_ram (
    .clk_i   (clk_i),
    .we_i    (app_second && !second_full),
    .waddr_i (ADDR_W'(second_len_q)),
    .wdata_i (in_item_i.symbol),
    .re_i    (req.b_re),
    .raddr_i (req.b_raddr),
    .rdata_o (b_rdata)
  );

  // cost row, entry k holds column k+1 of the current table row
  ed_ram #(
    .WIDTH (COST_W),
    .DEPTH (MAX_LEN)
  ) u_cost_ram (
    .clk_i   (clk_i),
    .we_i    (req.c_we),
    .waddr_i (req.c_waddr),
    .wdata_i (req.c_wdata),
    .re_i    (req.c_re),
    .raddr_i (req.c_raddr),
    .rdata_o (c_rdata)
  );

  ed_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .first_len_i  (first_len_q),
    .second_len_i (second_len_q),
    .a_rdata_i    (a_rdata),
    .b_rdata_i    (b_rdata),
    .c_rdata_i    (c_rdata),
    .out_free_i   (out_free),
    .req_o        (req),
    .busy_o       (ctrl_busy),
    .done_o       (ctrl_done),
    .dist_o       (ctrl_dist)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_done) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_done) begin
      out_item_q.distance  <= sat_dist(ctrl_dist);
      out_item_q.truncated <= trunc_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `ASSERT_IMPL(a_len_bound, 1'b1,
    first_len_q <= COST_W'(MAX_LEN) && second_len_q <= COST_W'(MAX_LEN))
  `ASSERT_IMPL(a_done_free, ctrl_done, out_free)
  `ASSERT_NEXT(a_compute_clears, start,
    first_len_q == '0 && second_len_q == '0 && !overflow_q && ctrl_busy)

endmodule

[verif/ed_result_checker.sv]
`timescale 1ns / 100ps

module ed_result_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  ed_pkg::in_item_t  in_item_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  ed_pkg::out_item_t out_item_i,
  output int                fail_count_o,
  output int                pending_o
);
  import ed_pkg::*;

  // two loaded strings, index 0 first, index 1 second
  logic [SYM_W-1:0] text [2][MAX_LEN];
  int               text_len [2];
  logic             dropped;
  out_item_t        owed_q [$];
  out_item_t        due;
  out_item_t        want;
  int               side;
  int               fails = 0;

  // row-by-row cost table over the loaded strings
  function automatic logic [DIST_W-1:0] lev_distance();
    int row [MAX_LEN+1];
    int diag;
    int above;
    int best;
    for (int j = 0; j <= MAX_LEN; j++) row[j] = j;
    for (int i = 1; i <= text_len[0]; i++) begin
      diag = row[0];
      row[0] = i;
      for (int j = 1; j <= text_len[1]; j++) begin
        above = row[j];
        if (text[0][i-1] == text[1][j-1]) begin
          row[j] = diag;
        end else begin
          best = (diag < above) ? diag : above;
          if (row[j-1] < best) best = row[j-1];
          row[j] = best + 1;
        end
        diag = above;
      end
    end
    if (row[text_len[1]] > DIST_MAX) return DIST_W'(DIST_MAX);
    return DIST_W'(row[text_len[1]]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_len[0] = 0;
      text_len[1] = 0;
      dropped = 1'b0;
      owed_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (owed_q.size() == 0) begin
          $error("unexpected item: distance %0d truncated %0b",
                 out_item_i.distance, out_item_i.truncated);
          fails++;
        end else begin
          want = owed_q.pop_front();
          if (out_item_i.distance !== want.distance) begin
            $error("distance: expected %0d, actual %0d", want.distance, out_item_i.distance);
            fails++;
          end
          if (out_item_i.truncated !== want.truncated) begin
            $error("truncated: expected %0b, actual %0b", want.truncated,
                   out_item_i.truncated);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        case (in_item_i.func)
          FUNC_APPEND_FIRST, FUNC_APPEND_SECOND: begin
            side = (in_item_i.func == FUNC_APPEND_SECOND) ? 1 : 0;
            if (text_len[side] < MAX_LEN) begin
              text[side][text_len[side]] = in_item_i.symbol;
              text_len[side]++;
            end else begin
              dropped = 1'b1;
            end
          end
          FUNC_COMPUTE: begin
            due.distance  = lev_distance();
            due.truncated = dropped;
            owed_q.push_back(due);
            text_len[0] = 0;
            text_len[1] = 0;
            dropped = 1'b0;
          end
          default: ;
        endcase
      end
    end
    fail_count_o <= fails;
    pending_o    <= owed_q.size();
  end

endmodule

[verif/tb_edit_distance_engine.sv]
`timescale 1ns / 100ps

module tb_edit_distance_engine;
  import ed_pkg::*;

  // func code the block swallows without effect
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // how the symbols of a string pair are drawn
  localparam int MIX_ANY   = 0;  // any byte
  localparam int MIX_FEW   = 1;  // three-letter alphabet, many matches
  localparam int MIX_NEAR  = 2;  // second string is an edited copy of the first
  localparam int MIX_APART = 3;  // disjoint byte ranges, no match at all

  localparam int ITEM_TARGET = 1600;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  int        fail_count;
  int        pending;
  int        sent = 0;
  bit        steady = 1'b0;

  always #1 clk_i = ~clk_i;

  edit_distance_engine DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  ed_result_checker u_result_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // sender gap: mostly none, some short, a few long; none at all while steady
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // string length: mostly short, now and then near or past capacity
  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return 0;
    if (r < 90) return $urandom_range(1, 10);
    return $urandom_range(MAX_LEN - 10, MAX_LEN + 6);
  endfunction

  // offer one item and hold it until the engine takes it;
  // entered and left right at a rising edge
  task automatic push_item(input logic [FUNC_W-1:0] fn, input logic [SYM_W-1:0] sym);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= '{func: fn, symbol: sym};
    do @(posedge clk_i); while (in_stall);
    if (fn != FUNC_UNUSED) sent++;
  endtask

  // hold off the sender until every owed distance has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // load a string pair with appends to both sides interleaved at random,
  // some noise items in between, and close with a compute when asked
  task automatic feed_string_pair(input int m, input int n, input int mix, input bit closed);
    logic [SYM_W-1:0] a [80];
    logic [SYM_W-1:0] b [80];
    logic [SYM_W-1:0] alpha [3];
    int ia;
    int ib;
    ia = 0;
    ib = 0;
    foreach (alpha[k]) alpha[k] = SYM_W'($urandom_range(0, 255));
    for (int k = 0; k < 80; k++) begin
      case (mix)
        MIX_ANY: begin
          a[k] = SYM_W'($urandom_range(0, 255));
          b[k] = SYM_W'($urandom_range(0, 255));
        end
        MIX_APART: begin
          a[k] = SYM_W'($urandom_range(0, 127));
          b[k] = SYM_W'($urandom_range(128, 255));
        end
        default: begin
          a[k] = alpha[$urandom_range(0, 2)];
          b[k] = alpha[$urandom_range(0, 2)];
        end
      endcase
    end
    // near copy: keep the aligned symbol, or shift by one, or substitute
    if (mix == MIX_NEAR) begin
      for (int k = 0; k < 79; k++) begin
        case ($urandom_range(0, 5))
          0:       b[k] = a[k+1];
          1:       b[k] = alpha[$urandom_range(0, 2)];
          default: b[k] = a[k];
        endcase
      end
    end
    while (ia < m || ib < n) begin
      if ($urandom_range(0, 24) == 0) push_item(FUNC_UNUSED, SYM_W'($urandom_range(0, 255)));
      if (ib >= n || (ia < m && $urandom_range(0, 1) == 1)) begin
        push_item(FUNC_APPEND_FIRST, a[ia]);
        ia++;
      end else begin
        push_item(FUNC_APPEND_SECOND, b[ib]);
        ib++;
      end
    end
    // the symbol of a compute item is junk and must not matter
    if (closed) push_item(FUNC_COMPUTE, SYM_W'($urandom_range(0, 255)));
  endtask

  // result side backpressure: bursts of stall, mostly short, a few long,
  // with calm stretches where nothing is held back
  initial begin
    int  free_run;
    int  busy_run;
    int  r;
    bit  calm;
    calm = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 19) == 0) calm = ~calm;
      r = $urandom_range(0, 99);
      free_run = calm ? $urandom_range(50, 200) : $urandom_range(1, 8);
      if (calm || r < 30) busy_run = 0;
      else if (r < 90) busy_run = $urandom_range(1, 4);
      else busy_run = $urandom_range(15, 60);
      out_stall <= 1'b0;
      repeat (free_run) @(posedge clk_i);
      if (busy_run > 0) begin
        out_stall <= 1'b1;
        repeat (busy_run) @(posedge clk_i);
      end
    end
  end

  initial begin
    string word_a;
    string word_b;
    int    m;
    int    n;
    word_a = "kitten";
    word_b = "sitting";
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: both empty, one side empty, extreme symbols, matching pair
    push_item(FUNC_COMPUTE, 8'hFF);
    push_item(FUNC_APPEND_FIRST, 8'h00);
    push_item(FUNC_COMPUTE, 8'h00);
    push_item(FUNC_APPEND_SECOND, 8'hFF);
    push_item(FUNC_COMPUTE, 8'h5A);
    push_item(FUNC_APPEND_FIRST, 8'hFF);
    // unused func between appends leaves the strings alone
    push_item(FUNC_UNUSED, 8'hAA);
    push_item(FUNC_APPEND_SECOND, 8'hFF);
    push_item(FUNC_COMPUTE, 8'h00);
    // textbook pair with insert, replace and match all needed
    for (int k = 0; k < word_a.len(); k++) push_item(FUNC_APPEND_FIRST, word_a[k]);
    for (int k = 0; k < word_b.len(); k++) push_item(FUNC_APPEND_SECOND, word_b[k]);
    push_item(FUNC_COMPUTE, 8'h00);
    settle();

    // both strings full with nothing in common: largest distance
    feed_string_pair(MAX_LEN, MAX_LEN, MIX_APART, 1'b1);
    // first string runs over capacity: symbols dropped, flag raised
    feed_string_pair(MAX_LEN + 6, 2, MIX_ANY, 1'b1);

    // random pairs; a few stay open so the next pair piles onto them
    while (sent < ITEM_TARGET) begin
      if ($urandom_range(0, 7) == 0) steady = ~steady;
      if ($urandom_range(0, 14) == 0) settle();
      m = pick_length();
      n = pick_length();
      feed_string_pair(m, n, $urandom_range(MIX_ANY, MIX_APART), $urandom_range(0, 9) != 0);
    end
    push_item(FUNC_COMPUTE, 8'h00);

    settle();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

[edit_distance_engine.f]
+incdir+rtl
rtl/ed_pkg.sv
rtl/ed_ram.sv
rtl/ed_cell.sv
rtl/ed_ctrl.sv
rtl/edit_distance_engine.sv
verif/ed_result_checker.sv
verif/tb_edit_distance_engine.sv
